>>> src/ffea_pkg.sv
// ffea_pkg: shared types, codes and default sizes for the first-fit extent allocator
// used by first_fit_extent_allocator; depends on nothing else
package ffea_pkg;

  // default sizes
  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_ADDR_BITS   = 32;

  // fixed field widths of the request and result beats
  localparam int LEN_W  = 32;
  localparam int STAT_W = 2;

  // request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERLAP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_INSERT
  } state_t;

endpackage

>>> src/first_fit_extent_allocator.sv
// first_fit_extent_allocator: first-fit free list with coalescing, table held in one
// synchronous memory of [start,end) pairs; depends on ffea_pkg
//
//  channel   handshake          payload                                    direction
//  request   start / busy       operation, region_length, region_position  in
//  result    done (one cycle)   granted_position, status                   out
//
// The scan reads one entry per cycle up to the entry that decides the request, and
// a shift then moves the entries above that point one per cycle, so scan and shift
// together cover the table once. The single read port of the extent memory sets
// this. Reset (rst, synchronous) empties the table and the space mark at once.
// busy is high from the accepting edge until the cycle before done; done lasts one
// cycle and must be taken then. The next beat can be taken at the edge that ends
// the done cycle.
module first_fit_extent_allocator #(
  parameter int MAX_EXTENTS = ffea_pkg::DEF_MAX_EXTENTS,
  parameter int ADDR_BITS   = ffea_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [ffea_pkg::LEN_W-1:0]    region_length,
  input  logic [ffea_pkg::LEN_W-1:0]    region_position,
  output logic                          done,
  output logic [ffea_pkg::LEN_W-1:0]    granted_position,
  output logic [ffea_pkg::STAT_W-1:0]   status
);
  import ffea_pkg::*;

  // stored value width, arithmetic width, index and count widths
  localparam int VW    = ADDR_BITS + 1;
  localparam int CW    = (VW > LEN_W + 1) ? VW : LEN_W + 1;
  localparam int IDX_W = $clog2(MAX_EXTENTS);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0]    LIMIT = {{(CW-1){1'b0}}, 1'b1} << ADDR_BITS;
  localparam logic [CNT_W-1:0] MAXC  = CNT_W'(MAX_EXTENTS);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  // extent memory, one {start, end} pair per entry
  logic [2*VW-1:0] ext_mem [MAX_EXTENTS];
  logic [2*VW-1:0] mem_q;
  logic [IDX_W-1:0] mem_ra, mem_wa;
  logic [2*VW-1:0] mem_wd;
  logic            mem_we;

  // control and request registers
  state_t           state, state_next;
  logic             op_r, op_r_next;
  logic [LEN_W-1:0] len_r, len_r_next;
  logic [LEN_W-1:0] pos_r, pos_r_next;
  logic [CW-1:0]    fend, fend_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0] chk_idx, chk_idx_next;
  logic             chk_vld, chk_vld_next;
  logic [CNT_W-1:0] ins_at, ins_at_next;
  logic [VW-1:0]    prev_s, prev_s_next;
  logic [VW-1:0]    prev_e, prev_e_next;
  logic             prev_vld, prev_vld_next;
  logic [CNT_W-1:0] count, count_next;
  logic [VW-1:0]    space_end, space_end_next;
  logic             done_next;
  logic [LEN_W-1:0] granted_position_next;
  logic [STAT_W-1:0] status_next;

  // memory entry and request values at arithmetic width
  logic [VW-1:0] q_s, q_e;
  logic [CW-1:0] q_s_w, q_e_w, len_w, pos_w, se_w, prev_e_w, new_s;
  logic [CNT_W-1:0] idx_m1, cnt_m1;
  logic [CNT_W-1:0] idx_m1_rd, idx_p1;

  assign q_s      = mem_q[2*VW-1:VW];
  assign q_e      = mem_q[VW-1:0];
  assign q_s_w    = CW'(q_s);
  assign q_e_w    = CW'(q_e);
  assign len_w    = CW'(len_r);
  assign pos_w    = CW'(pos_r);
  assign se_w     = CW'(space_end);
  assign prev_e_w = CW'(prev_e);
  assign new_s    = q_s_w + len_w;
  assign idx_m1   = chk_idx - ONE;
  assign cnt_m1   = count - ONE;
  assign idx_m1_rd = rd_idx - ONE;
  assign idx_p1    = chk_idx + ONE;

  // scan decision terms
  logic early, alloc_fit, free_stop, overlap, join_next, join_prev, exhausted, full;
  assign early     = (op_r == OP_FREE) && ((len_r == '0) || (fend > LIMIT));
  assign alloc_fit = chk_vld && ((q_e_w - q_s_w) >= len_w);
  assign free_stop = chk_vld && (q_s_w >= pos_w);
  assign overlap   = q_s_w < fend;
  assign join_next = q_s_w == fend;
  assign join_prev = prev_vld && (prev_e_w == pos_w);
  assign exhausted = !chk_vld && (rd_idx == count);
  assign full      = count >= MAXC;

  // scan decode: what the checked entry means for the request
  logic              sc_fin, sc_rm, sc_ins, sc_we, sc_se_ld, sc_keep_prev;
  logic [IDX_W-1:0]  sc_wa;
  logic [2*VW-1:0]   sc_wd;
  logic [LEN_W-1:0]  sc_pos;
  logic [STAT_W-1:0] sc_stat;
  logic [CNT_W-1:0]  sc_at;

  always_comb begin
    sc_fin       = 1'b0;
    sc_rm        = 1'b0;
    sc_ins       = 1'b0;
    sc_we        = 1'b0;
    sc_se_ld     = 1'b0;
    sc_keep_prev = 1'b0;
    sc_wa        = chk_idx[IDX_W-1:0];
    sc_wd        = mem_q;
    sc_pos       = '0;
    sc_stat      = STAT_OK;
    sc_at        = chk_idx;
    if (early) begin
      // zero-length free is a no-op, one past the space is rejected
      sc_fin  = 1'b1;
      sc_stat = (len_r == '0) ? STAT_OK : STAT_EXHAUSTED;
    end else if (op_r == OP_ALLOC) begin
      if (alloc_fit) begin
        sc_pos = q_s_w[LEN_W-1:0];
        if (new_s == q_e_w) begin
          sc_rm = 1'b1;
        end else begin
          sc_we  = 1'b1;
          sc_wd  = {VW'(new_s), q_e};
          sc_fin = 1'b1;
        end
      end else if (exhausted) begin
        sc_fin = 1'b1;
        if (len_w > (LIMIT - se_w)) begin
          sc_stat = STAT_EXHAUSTED;
        end else begin
          sc_pos   = se_w[LEN_W-1:0];
          sc_se_ld = 1'b1;
        end
      end
    end else begin
      if (free_stop) begin
        if (overlap) begin
          sc_fin  = 1'b1;
          sc_stat = STAT_OVERLAP;
        end else if (join_prev && join_next) begin
          sc_we = 1'b1;
          sc_wa = idx_m1[IDX_W-1:0];
          sc_wd = {prev_s, q_e};
          sc_rm = 1'b1;
        end else if (join_prev) begin
          sc_we  = 1'b1;
          sc_wa  = idx_m1[IDX_W-1:0];
          sc_wd  = {prev_s, VW'(fend)};
          sc_fin = 1'b1;
        end else if (join_next) begin
          sc_we  = 1'b1;
          sc_wd  = {VW'(pos_w), q_e};
          sc_fin = 1'b1;
        end else if (full) begin
          sc_fin  = 1'b1;
          sc_stat = STAT_FULL;
        end else begin
          sc_ins = 1'b1;
        end
      end else if (chk_vld) begin
        sc_keep_prev = 1'b1;
      end else if (exhausted) begin
        if (join_prev) begin
          sc_we  = 1'b1;
          sc_wa  = cnt_m1[IDX_W-1:0];
          sc_wd  = {prev_s, VW'(fend)};
          sc_fin = 1'b1;
        end else if (full) begin
          sc_fin  = 1'b1;
          sc_stat = STAT_FULL;
        end else begin
          sc_ins = 1'b1;
          sc_at  = count;
        end
      end
    end
  end

  // shift progress
  logic rm_issue, rm_end, in_issue, in_end;
  assign rm_issue = rd_idx < count;
  assign rm_end   = !chk_vld && (rd_idx == count);
  assign in_issue = rd_idx > ins_at;
  assign in_end   = !chk_vld && (rd_idx == ins_at);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sc_fin)      state_next = S_IDLE;
        else if (sc_rm)  state_next = S_REMOVE;
        else if (sc_ins) state_next = S_INSERT;
      end
      S_REMOVE: begin
        if (rm_end) state_next = S_IDLE;
      end
      S_INSERT: begin
        if (in_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_r_next             = op_r;
    len_r_next            = len_r;
    pos_r_next            = pos_r;
    fend_next             = fend;
    rd_idx_next           = rd_idx;
    chk_idx_next          = rd_idx;
    chk_vld_next          = 1'b0;
    ins_at_next           = ins_at;
    prev_s_next           = prev_s;
    prev_e_next           = prev_e;
    prev_vld_next         = prev_vld;
    count_next            = count;
    space_end_next        = space_end;
    done_next             = 1'b0;
    granted_position_next = granted_position;
    status_next           = status;
    mem_ra                = rd_idx[IDX_W-1:0];
    mem_we                = 1'b0;
    mem_wa                = chk_idx[IDX_W-1:0];
    mem_wd                = mem_q;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_r_next     = operation;
          len_r_next    = region_length;
          pos_r_next    = region_position;
          fend_next     = CW'(region_position) + CW'(region_length);
          rd_idx_next   = '0;
          prev_vld_next = 1'b0;
        end
      end
      S_SCAN: begin
        // stream reads one entry per cycle, check the one read last cycle
        if (rm_issue) rd_idx_next = rd_idx + ONE;
        chk_vld_next = rm_issue;
        mem_we = sc_we;
        mem_wa = sc_wa;
        mem_wd = sc_wd;
        if (sc_keep_prev) begin
          prev_s_next   = q_s;
          prev_e_next   = q_e;
          prev_vld_next = 1'b1;
        end
        if (sc_se_ld) space_end_next = VW'(se_w + len_w);
        if (sc_fin || sc_rm || sc_ins) begin
          granted_position_next = sc_pos;
          status_next           = sc_stat;
        end
        done_next = sc_fin;
        if (sc_rm) begin
          rd_idx_next  = chk_idx + ONE;
          chk_vld_next = 1'b0;
        end
        if (sc_ins) begin
          ins_at_next  = sc_at;
          rd_idx_next  = count;
          chk_vld_next = 1'b0;
        end
      end
      S_REMOVE: begin
        // entry k+1 moves down to k
        if (rm_issue) rd_idx_next = rd_idx + ONE;
        chk_vld_next = rm_issue;
        mem_we = chk_vld;
        mem_wa = idx_m1[IDX_W-1:0];
        if (rm_end) begin
          count_next = cnt_m1;
          done_next  = 1'b1;
        end
      end
      S_INSERT: begin
        // entry k-1 moves up to k, from the top down, then the new extent lands
        mem_ra       = idx_m1_rd[IDX_W-1:0];
        chk_idx_next = idx_m1_rd;
        if (in_issue) rd_idx_next = idx_m1_rd;
        chk_vld_next = in_issue;
        if (chk_vld) begin
          mem_we = 1'b1;
          mem_wa = idx_p1[IDX_W-1:0];
        end else if (in_end) begin
          mem_we     = 1'b1;
          mem_wa     = ins_at[IDX_W-1:0];
          mem_wd     = {VW'(pos_w), VW'(fend)};
          count_next = count + ONE;
          done_next  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // extent memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) ext_mem[mem_wa] <= mem_wd;
    mem_q <= ext_mem[mem_ra];
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      space_end <= '0;
      done      <= 1'b0;
      chk_vld   <= 1'b0;
      prev_vld  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      space_end <= space_end_next;
      done      <= done_next;
      chk_vld   <= chk_vld_next;
      prev_vld  <= prev_vld_next;
    end
    op_r             <= op_r_next;
    len_r            <= len_r_next;
    pos_r            <= pos_r_next;
    fend             <= fend_next;
    rd_idx           <= rd_idx_next;
    chk_idx          <= chk_idx_next;
    ins_at           <= ins_at_next;
    prev_s           <= prev_s_next;
    prev_e           <= prev_e_next;
    granted_position <= granted_position_next;
    status           <= status_next;
  end

  assign busy = (state != S_IDLE);

  // checks
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a request in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (granted_position == '0))
    else $error("failed request granted a nonzero position");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAXC)
    else $error("extent count above table depth");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for first_fit_extent_allocator, directed table then random beats
// depends on ffea_pkg and first_fit_extent_allocator; free-list behavior predicted in-bench
module tb_top;
  import ffea_pkg::*;

  localparam int EXT_DEPTH    = DEF_MAX_EXTENTS;
  localparam int ABITS        = DEF_ADDR_BITS;
  localparam int RAND_ITEMS   = 1330;
  localparam int PHASE_LEN    = 150;
  localparam int DRAIN_CYCLES = 2 * EXT_DEPTH + 16;
  localparam int DIR_ROWS     = 22;

  // one bit wider than an address so the top of the space fits
  typedef logic [ABITS:0] span_t;
  localparam span_t SPACE_TOP = span_t'(1) << ABITS;

  typedef struct packed {
    logic [LEN_W-1:0]  granted;
    logic [STAT_W-1:0] stat;
  } alloc_result_t;

  typedef struct packed {
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } region_t;

  typedef struct packed {
    logic              op;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    logic              typed;
    logic [LEN_W-1:0]  granted;
    logic [STAT_W-1:0] stat;
  } stim_row_t;

  // directed beats; typed expectations only where obvious
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_ALLOC, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, STAT_OK},
    '{OP_ALLOC, 32'h0000_0100, 32'h0000_0000, 1'b1, 32'h0000_0000, STAT_OK},
    '{OP_ALLOC, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 32'h0000_0100, STAT_OK},
    '{OP_FREE,  32'h0000_0000, 32'h0000_1234, 1'b1, 32'h0000_0000, STAT_OK},
    '{OP_FREE,  32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_EXHAUSTED},
    '{OP_FREE,  32'h0000_0080, 32'h0000_0100, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0040, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0040, 32'h0000_0040, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0080, 32'h0000_0080, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0010, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
    '{OP_ALLOC, 32'h0000_0200, 32'h5555_5555, 1'b0, 32'h0, STAT_OK},
    '{OP_ALLOC, 32'h0000_0180, 32'hAAAA_AAAA, 1'b0, 32'h0, STAT_OK},
    '{OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EXHAUSTED},
    '{OP_FREE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0, STAT_OK},
    '{OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
    '{OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
    '{OP_ALLOC, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0010, 32'h0000_1000, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'h0000_0004, 32'h0000_1008, 1'b0, 32'h0, STAT_OK},
    '{OP_FREE,  32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h0000_0000, STAT_EXHAUSTED},
    '{OP_FREE,  32'h0000_0010, 32'h0000_1004, 1'b0, 32'h0, STAT_OK}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              operation = OP_ALLOC;
  logic [LEN_W-1:0]  region_length = '0;
  logic [LEN_W-1:0]  region_position = '0;
  logic              done;
  logic [LEN_W-1:0]  granted_position;
  logic [STAT_W-1:0] status;

  first_fit_extent_allocator dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .region_length    (region_length),
    .region_position  (region_position),
    .done             (done),
    .granted_position (granted_position),
    .status           (status)
  );

  always #4 clk = ~clk;

  // free-list shadow: sorted extents and the high-water mark
  span_t       ext_lo [EXT_DEPTH];
  span_t       ext_hi [EXT_DEPTH];
  int unsigned ext_cnt = 0;
  span_t       space_mark = '0;

  alloc_result_t results_due [$];
  region_t       live_regions [$];
  region_t       freed_regions [$];
  int unsigned   err_count = 0;
  bit            steady = 1'b0;

  function automatic void extent_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < ext_cnt; k++) begin
      ext_lo[k] = ext_lo[k + 1];
      ext_hi[k] = ext_hi[k + 1];
    end
    ext_cnt--;
  endfunction

  function automatic void extent_insert(int unsigned idx, span_t lo, span_t hi);
    for (int unsigned k = ext_cnt; k > idx; k--) begin
      ext_lo[k] = ext_lo[k - 1];
      ext_hi[k] = ext_hi[k - 1];
    end
    ext_lo[idx] = lo;
    ext_hi[idx] = hi;
    ext_cnt++;
  endfunction

  // first-fit allocate or coalescing free; updates the shadow and returns the result beat
  function automatic alloc_result_t allocator_step(logic op, logic [LEN_W-1:0] len,
                                                   logic [LEN_W-1:0] pos);
    alloc_result_t r;
    span_t         l;
    span_t         p;
    span_t         e;
    int unsigned   i;
    bit            fit;
    bit            join_prev;
    bit            join_next;
    r.granted = '0;
    r.stat    = STAT_OK;
    l   = span_t'(len);
    p   = span_t'(pos);
    fit = 1'b0;
    if (op == OP_ALLOC) begin
      // first extent big enough, carved from its front
      for (i = 0; i < ext_cnt; i++) begin
        if (ext_hi[i] - ext_lo[i] >= l) begin
          fit       = 1'b1;
          r.granted = ext_lo[i][ABITS-1:0];
          ext_lo[i] = ext_lo[i] + l;
          if (ext_lo[i] == ext_hi[i]) extent_remove(i);
          break;
        end
      end
      // otherwise grow the space at the mark
      if (!fit) begin
        if (l > SPACE_TOP - space_mark) begin
          r.stat = STAT_EXHAUSTED;
        end else begin
          r.granted  = space_mark[ABITS-1:0];
          space_mark = space_mark + l;
        end
      end
    end else if (len != '0) begin
      if (l > SPACE_TOP - p) begin
        r.stat = STAT_EXHAUSTED;
      end else begin
        e = p + l;
        i = 0;
        while (i < ext_cnt && ext_lo[i] < p) i++;
        // only the following extent is checked for overlap
        if (i < ext_cnt && ext_lo[i] < e) begin
          r.stat = STAT_OVERLAP;
        end else begin
          join_next = (i < ext_cnt) && (ext_lo[i] == e);
          join_prev = (i > 0) && (ext_hi[i - 1] == p);
          if (join_prev && join_next) begin
            ext_hi[i - 1] = ext_hi[i];
            extent_remove(i);
          end else if (join_prev) begin
            ext_hi[i - 1] = e;
          end else if (join_next) begin
            ext_lo[i] = p;
          end else if (ext_cnt >= EXT_DEPTH) begin
            r.stat = STAT_FULL;
          end else begin
            extent_insert(i, p, e);
          end
        end
      end
    end
    return r;
  endfunction

  // drive one request beat, wait for it to be taken, queue its expected result
  task automatic issue_request(input logic op, input logic [LEN_W-1:0] len,
                               input logic [LEN_W-1:0] pos, input bit typed,
                               input alloc_result_t typed_res, output alloc_result_t got);
    alloc_result_t predicted;
    bit            accepted;
    accepted = 1'b0;
    // offer the beat each cycle until an edge takes it, dropping start on idle cycles
    while (!accepted) begin
      @(negedge clk);
      if (!steady && $urandom_range(99) < 31) begin
        start = 1'b0;
      end else begin
        start           = 1'b1;
        operation       = op;
        region_length   = len;
        region_position = pos;
      end
      @(posedge clk);
      accepted = start && !busy;
    end
    predicted = allocator_step(op, len, pos);
    results_due.push_back(typed ? typed_res : predicted);
    got = predicted;
    if (op == OP_ALLOC && predicted.stat == STAT_OK && len != '0)
      live_regions.push_back('{pos: predicted.granted, len: len});
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: granted_position %h status %0d",
               granted_position, status);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (granted_position !== want.granted) begin
          $error("granted_position: expected %h, actual %h", want.granted, granted_position);
          err_count++;
        end
        if (status !== want.stat) begin
          $error("status: expected %0d, actual %0d", want.stat, status);
          err_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    alloc_result_t got;
    alloc_result_t no_res;
    region_t       reg_pick;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
    int unsigned   pick;
    int unsigned   phase;
    int unsigned   idx;
    int unsigned   stride;
    bit            from_live;
    bit            want_alloc;
    no_res = '0;
    stride = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_request(DIRECTED[r].op, DIRECTED[r].len, DIRECTED[r].pos, DIRECTED[r].typed,
                    '{granted: DIRECTED[r].granted, stat: DIRECTED[r].stat}, got);
    end
    live_regions.delete();

    // random beats in phases: alloc-heavy, fragmenting frees, balanced
    for (int n = 0; n < RAND_ITEMS; n++) begin
      steady     = (n >= 600 && n < 780);
      phase      = (n / PHASE_LEN) % 3;
      pick       = $urandom_range(99);
      want_alloc = (phase == 0) ? (pick < 80) : (phase == 1) ? (pick < 20) : (pick < 50);
      from_live  = 1'b0;
      idx        = 0;
      if (want_alloc) begin
        pick = $urandom_range(99);
        if (pick < 2)
          len = '0;
        else if (pick < 3)
          len = $urandom;
        else if (pick < 15 && phase != 0)
          len = $urandom_range(1, 1 << 20);
        else
          len = $urandom_range(1, 256);
        issue_request(OP_ALLOC, len, $urandom, 1'b0, no_res, got);
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) begin
          len = '0;
          pos = $urandom;
        end else if (pick < 12 || live_regions.size() == 0) begin
          // noise: anywhere in the space, often oversized
          pos = $urandom;
          len = $urandom_range(1) ? $urandom : $urandom_range(1, 4096);
        end else if (pick < 17 && freed_regions.size() != 0) begin
          // double free of something returned lately
          reg_pick = freed_regions[$urandom_range(0, freed_regions.size() - 1)];
          pos = reg_pick.pos;
          len = reg_pick.len;
        end else begin
          // every other live region in the fragmenting phase leaves holes
          if (phase == 1 && $urandom_range(9) < 7)
            idx = stride++ % live_regions.size();
          else
            idx = $urandom_range(0, live_regions.size() - 1);
          reg_pick = live_regions[idx];
          live_regions.delete(idx);
          from_live = 1'b1;
          pos = reg_pick.pos;
          len = reg_pick.len;
        end
        issue_request(OP_FREE, len, pos, 1'b0, no_res, got);
        if (from_live) begin
          if (got.stat == STAT_OK) begin
            freed_regions.push_back(reg_pick);
            if (freed_regions.size() > 16) void'(freed_regions.pop_front());
          end else begin
            live_regions.insert(idx, reg_pick);
          end
        end
      end
    end

    @(negedge clk);
    start = 1'b0;

    // drain outstanding results, then allow for a stray beat
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
